// ----- hw/rtl/sha1hc_pkg.sv -----
// Shared types, constants and helpers of the SHA-1 hash core.
`default_nettype none

package sha1hc_pkg;

  localparam int WORD_W      = 32;
  localparam int SCHED_DEPTH = 16;
  localparam int CHAIN_DEPTH = 5;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [3:0]        slot_t;
  typedef logic [6:0]        round_t;
  typedef logic [2:0]        widx_t;
  typedef logic [2:0]        bcount_t;

  localparam bcount_t WORD_BYTES = 3'd4;
  localparam widx_t   LAST_IDX   = 3'd4;
  localparam round_t  LAST_ROUND = 7'd79;
  localparam round_t  SCHED_ROUNDS = 7'd16;
  localparam slot_t   LEN_HI_SLOT  = 4'd14;
  localparam slot_t   LAST_SLOT    = 4'd15;
  localparam slot_t   PRE_LEN_SLOT = 4'd13;
  localparam logic [7:0] PAD_BYTE  = 8'h80;

  localparam word_t K0 = 32'h5A82_7999;
  localparam word_t K1 = 32'h6ED9_EBA1;
  localparam word_t K2 = 32'h8F1B_BCDC;
  localparam word_t K3 = 32'hCA62_C1D6;

  localparam word_t IV [CHAIN_DEPTH] = '{
    32'h6745_2301, 32'hEFCD_AB89, 32'h98BA_DCFE, 32'h1032_5476, 32'hC3D2_E1F0
  };

  typedef enum logic [3:0] {
    S_IDLE,
    S_PAD80,
    S_ZERO,
    S_LENHI,
    S_LENLO,
    S_PRE,
    S_COMP,
    S_FOLD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic fold;
    logic init;
  } round_ctl_t;

  function automatic word_t rotl(input word_t x, input int n);
    rotl = (x << n) | (x >> (WORD_W - n));
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sha1hc_if.sv -----
// Request channels of the SHA-1 hash core: message words in, digest words out.
`default_nettype none

interface sha1hc_in_if;
  logic                     valid;
  logic                     ready;
  sha1hc_pkg::word_t        data_word;
  sha1hc_pkg::bcount_t      byte_count;
  logic                     last;

  modport source (output valid, data_word, byte_count, last, input ready);
  modport sink   (input valid, data_word, byte_count, last, output ready);
endinterface

interface sha1hc_out_if;
  logic                     valid;
  logic                     ready;
  sha1hc_pkg::word_t        digest_word;
  sha1hc_pkg::widx_t        word_index;
  logic                     final_word;

  modport source (output valid, digest_word, word_index, final_word, input ready);
  modport sink   (input valid, digest_word, word_index, final_word, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/sha1hc_ram.sv -----
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module sha1hc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1,
  output logic      [WIDTH-1:0]         rdata0,
  output logic      [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sha1hc_round.sv -----
// SHA-1 round datapath: working variables, chaining words and round function.
`default_nettype none

module sha1hc_round (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire sha1hc_pkg::round_ctl_t ctl,
  input  wire sha1hc_pkg::round_t     rnd,
  input  wire sha1hc_pkg::word_t      w,
  input  wire sha1hc_pkg::widx_t      sel,
  output sha1hc_pkg::word_t           digest
);
  import sha1hc_pkg::*;

  word_t h_r [CHAIN_DEPTH];
  word_t v_r [CHAIN_DEPTH];
  word_t f;
  word_t k;
  word_t tmp;

  always_comb begin
    if (rnd < 7'd20) begin
      f = (v_r[1] & v_r[2]) | (~v_r[1] & v_r[3]);
      k = K0;
    end else if (rnd < 7'd40) begin
      f = v_r[1] ^ v_r[2] ^ v_r[3];
      k = K1;
    end else if (rnd < 7'd60) begin
      f = (v_r[1] & v_r[2]) | (v_r[1] & v_r[3]) | (v_r[2] & v_r[3]);
      k = K2;
    end else begin
      f = v_r[1] ^ v_r[2] ^ v_r[3];
      k = K3;
    end
    tmp = rotl(v_r[0], 5) + f + v_r[4] + k + w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHAIN_DEPTH; i++) begin
        h_r[i] <= IV[i];
        v_r[i] <= '0;
      end
    end else begin
      if (ctl.init) begin
        for (int i = 0; i < CHAIN_DEPTH; i++) begin
          h_r[i] <= IV[i];
        end
      end else if (ctl.fold) begin
        for (int i = 0; i < CHAIN_DEPTH; i++) begin
          h_r[i] <= h_r[i] + v_r[i];
        end
      end
      if (ctl.load) begin
        for (int i = 0; i < CHAIN_DEPTH; i++) begin
          v_r[i] <= h_r[i];
        end
      end else if (ctl.step) begin
        v_r[0] <= tmp;
        v_r[1] <= v_r[0];
        v_r[2] <= rotl(v_r[1], 30);
        v_r[3] <= v_r[2];
        v_r[4] <= v_r[3];
      end
    end
  end

  assign digest = h_r[sel];

endmodule

`default_nettype wire

// ----- hw/rtl/sha1_hash_core.sv -----
// SHA-1 hash core top level: byte packing, padding, schedule memory and sequencing.
//
// Usage:
//   in_chan carries message words, first byte in bits 31..24, with byte_count
//   valid leading bytes (values above four count as four) and last on the
//   final word. Short words may appear anywhere; bytes simply concatenate.
//   out_chan returns the 160-bit digest as five words, h0 first, word_index
//   0..4, final_word set on the fifth.
//   A word that does not fill a 512-bit block and is not last leaves the core
//   ready for the next word. The sixteenth word of a block starts the
//   compression: a prefetch step, 80 rounds at one per cycle and a fold step,
//   during which in_chan.ready is low.
//   On last the core writes the padding and length words one per cycle, runs
//   one or two more compressions, then offers the five digest words, one per
//   cycle while out_chan.ready is high. A stalled receiver holds the digest
//   phase; the fifth word sits in the output register while the next message
//   is already accepted.
//   Reset (rst_n low, synchronous) loads the initial chaining words and empties
//   the block; no clearing pass is needed.
`default_nettype none

module sha1_hash_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sha1hc_in_if.sink  in_chan,
  sha1hc_out_if.source out_chan
);
  import sha1hc_pkg::*;

  state_t      state_r, state_nxt;
  state_t      after_r, after_nxt;
  round_t      rnd_r, rnd_nxt;
  slot_t       wfill_r, wfill_nxt;
  word_t       acc_r, acc_nxt;
  logic [1:0]  acc_n_r, acc_n_nxt;
  logic [63:0] bits_r, bits_nxt;
  widx_t       oidx_r, oidx_nxt;
  logic        out_valid_r, out_valid_nxt;
  word_t       out_word_r;
  widx_t       out_idx_r;
  logic        out_final_r;

  logic        accept;
  logic        out_load;
  bcount_t     cnt_c;
  bcount_t     total;
  bcount_t     total_less;
  logic        complete;
  word_t       data_m;
  word_t       acc_m;
  logic [63:0] packed_w;

  logic        ram_we;
  slot_t       ram_waddr;
  word_t       ram_wdata;
  slot_t       u;
  word_t       qa0, qa1, qb0, qb1;
  word_t       w_cur;
  word_t       digest;
  round_ctl_t  ctl;

  // Byte packing
  always_comb begin
    cnt_c      = (in_chan.byte_count > WORD_BYTES) ? WORD_BYTES : in_chan.byte_count;
    data_m     = in_chan.data_word & ~(32'hFFFF_FFFF >> {cnt_c, 3'b000});
    acc_m      = acc_r & ~(32'hFFFF_FFFF >> {acc_n_r, 3'b000});
    packed_w   = {acc_m, 32'h0} | ({data_m, 32'h0} >> {acc_n_r, 3'b000});
    total      = {1'b0, acc_n_r} + cnt_c;
    total_less = total - WORD_BYTES;
    complete   = (total >= WORD_BYTES);
  end

  assign accept   = in_chan.valid && in_chan.ready;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_chan.ready);

  assign w_cur = (rnd_r < SCHED_ROUNDS) ? qa0 : rotl(qb1 ^ qb0 ^ qa1 ^ qa0, 1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r) inside
      S_IDLE: begin
        if (accept) begin
          if (complete && (wfill_r == LAST_SLOT)) begin
            state_nxt = S_PRE;
          end else if (in_chan.last) begin
            state_nxt = S_PAD80;
          end
        end
      end
      S_PAD80, S_ZERO: begin
        if (wfill_r == PRE_LEN_SLOT) begin
          state_nxt = S_LENHI;
        end else if (wfill_r == LAST_SLOT) begin
          state_nxt = S_PRE;
        end else begin
          state_nxt = S_ZERO;
        end
      end
      S_LENHI: state_nxt = S_LENLO;
      S_LENLO: state_nxt = S_PRE;
      S_PRE:   state_nxt = S_COMP;
      S_COMP: begin
        if (rnd_r == LAST_ROUND) begin
          state_nxt = S_FOLD;
        end
      end
      S_FOLD:  state_nxt = after_r;
      S_OUT: begin
        if (out_load && (oidx_r == LAST_IDX)) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs and datapath control
  always_comb begin
    in_chan.ready = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = wfill_r;
    ram_wdata     = packed_w[63:32];
    ctl           = '0;
    u             = rnd_r[3:0] + 4'd1;
    after_nxt     = after_r;
    rnd_nxt       = rnd_r;
    acc_nxt       = acc_r;
    acc_n_nxt     = acc_n_r;
    bits_nxt      = bits_r;
    oidx_nxt      = oidx_r;
    unique case (state_r)
      S_IDLE: begin
        in_chan.ready = 1'b1;
        if (accept) begin
          ram_we   = complete;
          bits_nxt = bits_r + {58'h0, cnt_c, 3'b000};
          if (complete) begin
            acc_nxt   = packed_w[31:0];
            acc_n_nxt = total_less[1:0];
          end else begin
            acc_nxt   = packed_w[63:32];
            acc_n_nxt = total[1:0];
          end
          after_nxt = in_chan.last ? S_PAD80 : S_IDLE;
        end
      end
      S_PAD80: begin
        ram_we    = 1'b1;
        ram_wdata = acc_m | ({PAD_BYTE, 24'h0} >> {acc_n_r, 3'b000});
        acc_n_nxt = 2'd0;
        after_nxt = S_ZERO;
      end
      S_ZERO: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        after_nxt = S_ZERO;
      end
      S_LENHI: begin
        ram_we    = 1'b1;
        ram_wdata = bits_r[63:32];
      end
      S_LENLO: begin
        ram_we    = 1'b1;
        ram_wdata = bits_r[31:0];
        bits_nxt  = '0;
        after_nxt = S_OUT;
      end
      S_PRE: begin
        ctl.load = 1'b1;
        u        = '0;
        rnd_nxt  = '0;
      end
      S_COMP: begin
        ctl.step  = 1'b1;
        ram_we    = (rnd_r >= SCHED_ROUNDS);
        ram_waddr = rnd_r[3:0];
        ram_wdata = w_cur;
        rnd_nxt   = rnd_r + 7'd1;
      end
      S_FOLD: begin
        ctl.fold = 1'b1;
      end
      S_OUT: begin
        if (out_load) begin
          if (oidx_r == LAST_IDX) begin
            oidx_nxt = '0;
            ctl.init = 1'b1;
          end else begin
            oidx_nxt = oidx_r + 3'd1;
          end
        end
      end
      default: ;
    endcase
  end

  assign wfill_nxt     = (ram_we && (state_r != S_COMP)) ? wfill_r + 4'd1 : wfill_r;
  assign out_valid_nxt = out_load ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      after_r     <= S_IDLE;
      rnd_r       <= '0;
      wfill_r     <= '0;
      acc_n_r     <= '0;
      bits_r      <= '0;
      oidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      after_r     <= after_nxt;
      rnd_r       <= rnd_nxt;
      wfill_r     <= wfill_nxt;
      acc_n_r     <= acc_n_nxt;
      bits_r      <= bits_nxt;
      oidx_r      <= oidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (out_load) begin
      out_word_r  <= digest;
      out_idx_r   <= oidx_r;
      out_final_r <= (oidx_r == LAST_IDX);
    end
  end

  // Schedule window: two copies, four read taps per round
  sha1hc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SCHED_DEPTH)
  ) u_ram_a (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr0 (u),
    .raddr1 (u + 4'd2),
    .rdata0 (qa0),
    .rdata1 (qa1)
  );

  sha1hc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SCHED_DEPTH)
  ) u_ram_b (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .raddr0 (u + 4'd8),
    .raddr1 (u + 4'd13),
    .rdata0 (qb0),
    .rdata1 (qb1)
  );

  sha1hc_round u_round (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .rnd    (rnd_r),
    .w      (w_cur),
    .sel    (oidx_r),
    .digest (digest)
  );

  assign out_chan.valid       = out_valid_r;
  assign out_chan.digest_word = out_word_r;
  assign out_chan.word_index  = out_idx_r;
  assign out_chan.final_word  = out_final_r;

  a_fold_ret: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FOLD |=> state_r == $past(after_r))
    else $error("fold did not return to the recorded state");

  a_last_round: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMP && rnd_r == LAST_ROUND) |=> state_r == S_FOLD)
    else $error("compression did not end after the last round");

  a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PRE |-> wfill_r == 4'd0)
    else $error("compression started on a partial block");

  a_len_slot: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LENHI |-> (wfill_r == LEN_HI_SLOT && acc_n_r == 2'd0))
    else $error("length written at the wrong slot");

  a_final_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_final_r) |-> out_idx_r == LAST_IDX)
    else $error("final flag on a digest word other than h4");

endmodule

`default_nettype wire
